### hdl/assert_macros.svh
// Assertion helpers used by the top-level filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define BF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bilateral filter assertion failed");

// Check that the consequence holds in the cycle after the antecedent.
`define BF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bilateral filter assertion failed");

`endif

### hdl/bf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bf_pkg;

  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int W_W         = 17;
  localparam int PIX_W       = 8;
  localparam int TAPS        = 25;
  localparam int TAP_W       = 5;
  localparam int CENTER      = 12;
  localparam int RANGE_DEPTH = 256;
  localparam int PROD_W      = 2 * W_W;
  localparam int WW_W        = PROD_W - WEIGHT_FRAC_BITS;
  localparam int WV_W        = WW_W + PIX_W;
  localparam int WS_W        = WW_W + TAP_W;
  localparam int VS_W        = WS_W + PIX_W;
  localparam int NUM_W       = VS_W + 2;
  localparam int DEN_W       = WS_W + 1;

  localparam logic [1:0] FUNC_PIX     = 2'd0;
  localparam logic [1:0] FUNC_SPATIAL = 2'd1;
  localparam logic [1:0] FUNC_RANGE   = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       table_index;
    logic [W_W-1:0]   weight_value;
    logic [PIX_W-1:0] pix_row0;
    logic [PIX_W-1:0] pix_row1;
    logic [PIX_W-1:0] pix_row2;
    logic [PIX_W-1:0] pix_row3;
    logic [PIX_W-1:0] pix_row4;
    logic             first_column;
    logic             last_column;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;
  } out_word_t;

  typedef logic [TAPS-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic           sp_we;
    logic           rg_we;
    logic [7:0]     idx;
    logic [W_W-1:0] val;
  } tbl_wr_t;

  typedef struct packed {
    logic            done;
    logic [WS_W-1:0] ws;
    logic [VS_W-1:0] vs;
  } mac_res_t;

endpackage
`default_nettype wire

### hdl/bilateral_filter_5x5_u8.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// 5x5 bilateral filter on 8-bit pixels, fed one image column (rows y-2..y+2)
// per input word. Load words (func 1/2) write the spatial and range weight
// tables. A pixel column yields zero to three output words; each output
// pixel takes a sweep of the taps through the single read port of the
// range-table RAM, a 4-stage multiply/accumulate tail, and a serial
// divider. Input stall stays high until every output word of the current
// column sits in the output register. The weight tables come up undefined
// and must be loaded before filtering.
module bilateral_filter_5x5_u8 import bf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEXT = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] st_q, st_d;
  win_t       win_q, win_d;
  logic [1:0] cnt_q, cnt_d, seen_q, seen_d, fl_q, fl_d, cnt_new;
  logic       main_q, main_d, re_q, re_d;
  logic       in_acc, pix_acc, mac_start, div_start, out_load;
  logic [PIX_W-1:0] res_q, res_d;
  logic       out_valid_q;
  out_word_t  out_q;
  tbl_wr_t    tbl_wr;
  mac_res_t   mac_res;
  logic       mac_busy, div_done;
  logic [PIX_W-1:0] div_q;
  logic [4:0][PIX_W-1:0] col;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (in_word_i.func == FUNC_PIX);

  // table writes go straight to the weight RAMs
  assign tbl_wr.sp_we = in_acc && (in_word_i.func == FUNC_SPATIAL)
                        && (in_word_i.table_index < 8'(TAPS));
  assign tbl_wr.rg_we = in_acc && (in_word_i.func == FUNC_RANGE);
  assign tbl_wr.idx   = in_word_i.table_index;
  assign tbl_wr.val   = in_word_i.weight_value;

  assign col = {in_word_i.pix_row4, in_word_i.pix_row3, in_word_i.pix_row2,
                in_word_i.pix_row1, in_word_i.pix_row0};
  assign cnt_new = in_word_i.first_column ? 2'd1
                 : ((cnt_q == 2'd3) ? 2'd3 : cnt_q + 2'd1);

  always_comb begin
    st_d      = st_q;
    win_d     = win_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    fl_d      = fl_q;
    main_d    = main_q;
    re_d      = re_q;
    res_d     = res_q;
    mac_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (pix_acc) begin
          // refill on a row start, else shift the new column in
          for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 4; c++) begin
              win_d[r*5+c] = in_word_i.first_column ? col[r] : win_q[r*5+c+1];
            end
            win_d[r*5+4] = col[r];
          end
          seen_d = cnt_new;
          main_d = (cnt_new == 2'd3);
          fl_d   = in_word_i.last_column ? 2'd2 : 2'd0;
          cnt_d  = in_word_i.last_column ? 2'd0 : cnt_new;
          st_d   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (main_q) begin
          main_d    = 1'b0;
          re_d      = 1'b0;
          mac_start = 1'b1;
          st_d      = ST_MAC;
        end else if (fl_q != 2'd0) begin
          // flush: replicate the newest column, emit only pixels still owed
          for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 4; c++) begin
              win_d[r*5+c] = win_q[r*5+c+1];
            end
          end
          fl_d = fl_q - 2'd1;
          if (fl_q == 2'd1 || seen_q >= 2'd2) begin
            re_d      = (fl_q == 2'd1);
            mac_start = 1'b1;
            st_d      = ST_MAC;
          end
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_MAC: begin
        if (mac_res.done) begin
          div_start = 1'b1;
          st_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d = div_q;
          st_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          st_d     = ST_NEXT;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      win_q       <= '0;
      cnt_q       <= '0;
      seen_q      <= '0;
      fl_q        <= '0;
      main_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      win_q  <= win_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      fl_q   <= fl_d;
      main_q <= main_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    re_q  <= re_d;
    res_q <= res_d;
    if (out_load) begin
      out_q.out_pixel <= res_q;
      out_q.row_end   <= re_q;
    end
  end

  bf_mac u_mac (
    .clk_i,
    .rst_ni,
    .start_i(mac_start),
    .win_i  (win_q),
    .wr_i   (tbl_wr),
    .busy_o (mac_busy),
    .res_o  (mac_res)
  );

  bf_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .ws_i    (mac_res.ws),
    .vs_i    (mac_res.vs),
    .center_i(win_q[CENTER]),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `BF_ASSERT_IMP(a_mac_idle_on_start, mac_start, !mac_busy)
  `BF_ASSERT_IMP(a_no_overwrite, out_load && out_valid_q, !out_stall_i)
  `BF_ASSERT_IMP(a_div_done_state, div_done, st_q == ST_DIV)
  `BF_ASSERT_NEXT(a_flush_armed, pix_acc && in_word_i.last_column, fl_q == 2'd2)
endmodule
`default_nettype wire

### hdl/bf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/bf_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module bf_mac import bf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire win_t    win_i,
  input  wire tbl_wr_t wr_i,
  output logic         busy_o,
  output mac_res_t     res_o
);
  logic             busy_q, v1_q, v2_q, v3_q, done_q;
  logic             last1_q, last2_q, last3_q;
  logic [TAP_W-1:0] k_q;
  logic [PIX_W-1:0] tap_pix, ctr_pix, diff, pix1_q, pix2_q;
  logic [W_W-1:0]   sp_rd, rg_rd;
  logic [PROD_W-1:0] p_q;
  logic [WW_W-1:0]  ww, ww_q;
  logic [WV_W-1:0]  wv_q;
  logic [WS_W-1:0]  ws_q;
  logic [VS_W-1:0]  vs_q;

  assign tap_pix = win_i[k_q];
  assign ctr_pix = win_i[CENTER];
  assign diff    = (tap_pix > ctr_pix) ? tap_pix - ctr_pix : ctr_pix - tap_pix;
  assign ww      = p_q[WEIGHT_FRAC_BITS +: WW_W];

  bf_ram #(.WIDTH(W_W), .DEPTH(TAPS)) u_spatial (
    .clk_i,
    .we_i   (wr_i.sp_we),
    .waddr_i(wr_i.idx[TAP_W-1:0]),
    .wdata_i(wr_i.val),
    .raddr_i(k_q),
    .rdata_o(sp_rd)
  );

  bf_ram #(.WIDTH(W_W), .DEPTH(RANGE_DEPTH)) u_range (
    .clk_i,
    .we_i   (wr_i.rg_we),
    .waddr_i(wr_i.idx),
    .wdata_i(wr_i.val),
    .raddr_i(diff),
    .rdata_o(rg_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
      last3_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      // sweep the taps, one table read pair a cycle
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q) begin
        k_q <= k_q + 1'b1;
        if (k_q == TAP_W'(TAPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
      v1_q    <= busy_q;
      last1_q <= busy_q && (k_q == TAP_W'(TAPS - 1));
      v2_q    <= v1_q;
      last2_q <= last1_q;
      v3_q    <= v2_q;
      last3_q <= last2_q;
      done_q  <= v3_q && last3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix1_q <= tap_pix;
    pix2_q <= pix1_q;
    p_q    <= PROD_W'(sp_rd) * PROD_W'(rg_rd);
    ww_q   <= ww;
    wv_q   <= WV_W'(ww) * WV_W'(pix2_q);
    if (start_i) begin
      ws_q <= '0;
      vs_q <= '0;
    end else if (v3_q) begin
      ws_q <= ws_q + WS_W'(ww_q);
      vs_q <= vs_q + VS_W'(wv_q);
    end
  end

  assign busy_o     = busy_q | v1_q | v2_q | v3_q | done_q;
  assign res_o.done = done_q;
  assign res_o.ws   = ws_q;
  assign res_o.vs   = vs_q;
endmodule
`default_nettype wire

### hdl/bf_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bf_div import bf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WS_W-1:0]  ws_i,
  input  wire logic [VS_W-1:0]  vs_i,
  input  wire logic [PIX_W-1:0] center_i,
  output logic                  done_o,
  output logic [PIX_W-1:0]      quot_o
);
  localparam logic [1:0] DV_IDLE  = 2'd0;
  localparam logic [1:0] DV_CHECK = 2'd1;
  localparam logic [1:0] DV_ITER  = 2'd2;

  logic [1:0]       st_q;
  logic [2:0]       i_q;
  logic             done_q;
  logic [NUM_W-1:0] num_q, trial, limit;
  logic [DEN_W-1:0] den_q;
  logic [PIX_W-1:0] q_q;

  assign trial = NUM_W'(den_q) << i_q;
  assign limit = NUM_W'(den_q) << PIX_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DV_IDLE;
      i_q    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        DV_IDLE: begin
          if (start_i) begin
            st_q <= DV_CHECK;
          end
        end
        DV_CHECK: begin
          if (den_q == '0 || num_q >= limit) begin
            done_q <= 1'b1;
            st_q   <= DV_IDLE;
          end else begin
            i_q  <= 3'd7;
            st_q <= DV_ITER;
          end
        end
        DV_ITER: begin
          i_q <= i_q - 1'b1;
          if (i_q == '0) begin
            done_q <= 1'b1;
            st_q   <= DV_IDLE;
          end
        end
        default: st_q <= DV_IDLE;
      endcase
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    case (st_q)
      DV_IDLE: begin
        num_q <= (NUM_W'(vs_i) << 1) + NUM_W'(ws_i);
        den_q <= {ws_i, 1'b0};
        q_q   <= center_i;
      end
      DV_CHECK: begin
        if (den_q != '0) begin
          q_q <= (num_q >= limit) ? '1 : '0;
        end
      end
      DV_ITER: begin
        if (num_q >= trial) begin
          num_q    <= num_q - trial;
          q_q[i_q] <= 1'b1;
        end
      end
      default: q_q <= q_q;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule
`default_nettype wire
